// ----- sv/mkey_pkg.sv -----
// Shared types, constants and Morse code tables for the paddle and text keyer.
// No dependencies; used by mkey_queue and morse_paddle_and_text_keyer_core.
package mkey_pkg;

    localparam int DIT_W   = 11;
    localparam int TIMER_W = 14;
    localparam int CHAR_W  = 8;
    localparam int IN_W    = 11;
    localparam int OUT_W   = 20;

    localparam logic [DIT_W-1:0]  DIT_RESET   = 11'd100;
    localparam logic [CHAR_W-1:0] MARKER_LAST = 8'h80;

    // keyer sequencing modes
    typedef enum logic [5:0] {
        M_START = 6'b000001,
        M_DIT   = 6'b000010,
        M_DAH   = 6'b000100,
        M_ECHAR = 6'b001000,
        M_EWORD = 6'b010000,
        M_ASCII = 6'b100000
    } t_mode;

    // key line phases
    typedef enum logic [3:0] {
        PH_IDLE  = 4'b0001,
        PH_MARK  = 4'b0010,
        PH_SPACE = 4'b0100,
        PH_GAP   = 4'b1000
    } t_phase;

    // Element pattern: LSB first, dah = 1, marker bit above the last element.
    function automatic logic [CHAR_W-1:0] pattern_of_char(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] p;
        case (c)
            "A": p = 8'd6;   "B": p = 8'd17;  "C": p = 8'd21;  "D": p = 8'd9;
            "E": p = 8'd2;   "F": p = 8'd20;  "G": p = 8'd11;  "H": p = 8'd16;
            "I": p = 8'd4;   "J": p = 8'd30;  "K": p = 8'd13;  "L": p = 8'd18;
            "M": p = 8'd7;   "N": p = 8'd5;   "O": p = 8'd15;  "P": p = 8'd22;
            "Q": p = 8'd27;  "R": p = 8'd10;  "S": p = 8'd8;   "T": p = 8'd3;
            "U": p = 8'd12;  "V": p = 8'd24;  "W": p = 8'd14;  "X": p = 8'd25;
            "Y": p = 8'd29;  "Z": p = 8'd19;
            "0": p = 8'd63;  "1": p = 8'd62;  "2": p = 8'd60;  "3": p = 8'd56;
            "4": p = 8'd48;  "5": p = 8'd32;  "6": p = 8'd33;  "7": p = 8'd35;
            "8": p = 8'd39;  "9": p = 8'd47;
            ".": p = 8'd106; ",": p = 8'd115; "?": p = 8'd76;  "'": p = 8'd94;
            "!": p = 8'd117; "/": p = 8'd41;  "(": p = 8'd45;  ")": p = 8'd109;
            "&": p = 8'd34;  ":": p = 8'd71;  ";": p = 8'd85;  "=": p = 8'd49;
            "+": p = 8'd42;  "-": p = 8'd97;  "_": p = 8'd108; "\"": p = 8'd82;
            "$": p = 8'd200; "@": p = 8'd86;
            default: p = 8'd0;
        endcase
        return p;
    endfunction

    function automatic logic [CHAR_W-1:0] char_of_pattern(input logic [CHAR_W-1:0] p);
        logic [CHAR_W-1:0] c;
        case (p)
            8'd6:   c = "A"; 8'd17:  c = "B"; 8'd21:  c = "C"; 8'd9:   c = "D";
            8'd2:   c = "E"; 8'd20:  c = "F"; 8'd11:  c = "G"; 8'd16:  c = "H";
            8'd4:   c = "I"; 8'd30:  c = "J"; 8'd13:  c = "K"; 8'd18:  c = "L";
            8'd7:   c = "M"; 8'd5:   c = "N"; 8'd15:  c = "O"; 8'd22:  c = "P";
            8'd27:  c = "Q"; 8'd10:  c = "R"; 8'd8:   c = "S"; 8'd3:   c = "T";
            8'd12:  c = "U"; 8'd24:  c = "V"; 8'd14:  c = "W"; 8'd25:  c = "X";
            8'd29:  c = "Y"; 8'd19:  c = "Z";
            8'd63:  c = "0"; 8'd62:  c = "1"; 8'd60:  c = "2"; 8'd56:  c = "3";
            8'd48:  c = "4"; 8'd32:  c = "5"; 8'd33:  c = "6"; 8'd35:  c = "7";
            8'd39:  c = "8"; 8'd47:  c = "9";
            8'd106: c = "."; 8'd115: c = ","; 8'd76:  c = "?"; 8'd94:  c = "'";
            8'd117: c = "!"; 8'd41:  c = "/"; 8'd45:  c = "("; 8'd109: c = ")";
            8'd34:  c = "&"; 8'd71:  c = ":"; 8'd85:  c = ";"; 8'd49:  c = "=";
            8'd42:  c = "+"; 8'd97:  c = "-"; 8'd108: c = "_"; 8'd82:  c = "\"";
            8'd200: c = "$"; 8'd86:  c = "@";
            default: c = 8'd0;
        endcase
        return c;
    endfunction

endpackage

// ----- sv/mkey_queue.sv -----
// Text queue for the keyer: circular buffer memory with head look-ahead read.
// Depends on mkey_pkg for the character width.
module mkey_queue #(
    parameter int DEPTH = 128
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  logic [mkey_pkg::CHAR_W-1:0] i_push_data,
    input  logic                        i_pop,
    output logic [mkey_pkg::CHAR_W-1:0] o_head_data,
    output logic [$clog2(DEPTH+1)-1:0]  o_count,
    output logic                        o_full
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    logic [mkey_pkg::CHAR_W-1:0] mem [DEPTH];
    logic [mkey_pkg::CHAR_W-1:0] r_rdata;
    logic [AW-1:0] r_head, r_tail, n_head, n_tail;
    logic [CW-1:0] r_count, n_count;

    // pointer and occupancy updates
    always_comb begin
        n_head  = i_pop  ? ((r_head == LAST) ? '0 : r_head + 1'b1) : r_head;
        n_tail  = i_push ? ((r_tail == LAST) ? '0 : r_tail + 1'b1) : r_tail;
        n_count = r_count + CW'(i_push) - CW'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    // memory write, and read of the next head entry with write bypass
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            mem[r_tail] <= i_push_data;
        end
        if (i_push && (r_tail == n_head)) begin
            r_rdata <= i_push_data;
        end else begin
            r_rdata <= mem[n_head];
        end
    end

    // an entry pushed into an empty queue is seen at once
    assign o_head_data = (r_count == '0) ? i_push_data : r_rdata;
    assign o_count     = r_count;
    assign o_full      = (r_count >= CW'(DEPTH));

endmodule

// ----- sv/morse_paddle_and_text_keyer_core.sv -----
// Top level of the iambic paddle and text Morse keyer with paddle decoding.
// Depends on mkey_pkg and mkey_queue.
//
// Usage: each slave transaction is one millisecond tick carrying the paddle
// levels and an optional received text byte; each tick yields exactly one
// master transaction with the key line, a decoded paddle character, an echo
// of a sent text character and the queue-full flag for that tick.
// The result of a tick is in the output register on the cycle after acceptance.
// Throughput is one tick per cycle while the receiver takes results, set by the
// single pass of sequencer logic between the state registers; the queue memory
// has one write and one read port and reads the next head entry every cycle.
// The output register frees itself when taken, so a new tick is accepted in
// the same cycle as the previous result leaves. While the receiver stalls,
// the held result stays and s_tready is low, so no tick is taken.
// dit_length is written through i_cfg_wr_en / i_cfg_wr_data; the user must do so only while
// idle, as the block does not enforce it. A value of 0 acts as 1.
// Reset (synchronous, active low) returns to the start mode, empties the
// queue, clears the output valid flag and sets dit_length to 100.
module morse_paddle_and_text_keyer_core #(
    parameter int QUEUE_DEPTH = 128
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [mkey_pkg::DIT_W-1:0] i_cfg_wr_data,
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    // [0] dit_pressed, [1] dah_pressed, [2] rx_valid, [10:3] rx_byte
    input  logic [15:0]                i_s_tdata,
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    // [0] key_on, [1] decoded_valid, [9:2] decoded_char, [10] echo_valid,
    // [18:11] echo_char, [19] queue_full
    output logic [23:0]                o_m_tdata
);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int TW = mkey_pkg::TIMER_W;
    localparam int CH = mkey_pkg::CHAR_W;

    logic                          accept;
    logic                          dit, dah, rx_valid;
    logic [CH-1:0]                 rx_byte, rx_fold;
    logic                          push, pop, full;
    logic [CH-1:0]                 head_data;
    logic [CW-1:0]                 q_count;
    logic                          cnt_nz, cnt_nz_after;

    logic [mkey_pkg::DIT_W-1:0]    r_dit_len;
    mkey_pkg::t_mode               r_mode, n_mode;
    mkey_pkg::t_phase              r_phase, n_phase;
    logic [CH-1:0]                 r_elem, n_elem, r_marker, n_marker;
    logic [CH-1:0]                 r_spat, n_spat, r_schar, n_schar;
    logic [TW-1:0]                 r_timer, n_timer;
    logic                          r_out_valid;
    logic [mkey_pkg::OUT_W-1:0]    r_out_data, n_out_data;

    logic [TW-1:0] dl1, dl2, dl3, dl4, dl7;
    logic          key, dv, ev;
    logic [CH-1:0] dc, ec;

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign accept     = i_s_tvalid && o_s_tready;

    assign dit      = i_s_tdata[0];
    assign dah      = i_s_tdata[1];
    assign rx_valid = i_s_tdata[2];
    assign rx_byte  = i_s_tdata[10:3];

    // case folding of received letters
    assign rx_fold = ((rx_byte >= "a") && (rx_byte <= "z")) ? (rx_byte - 8'd32) : rx_byte;

    assign push         = accept && rx_valid && !full;
    assign cnt_nz       = (q_count != '0) || push;
    assign cnt_nz_after = ((q_count + CW'(push)) > CW'(pop));

    mkey_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (rx_fold),
        .i_pop       (pop),
        .o_head_data (head_data),
        .o_count     (q_count),
        .o_full      (full)
    );

    // phase lengths from the dit length
    always_comb begin
        dl1 = (r_dit_len == '0) ? TW'(1) : TW'(r_dit_len);
        dl2 = dl1 << 1;
        dl3 = dl1 + dl2;
        dl4 = dl1 << 2;
        dl7 = (dl1 << 3) - dl1;
    end

    // one tick of the keyer sequencer
    always_comb begin
        n_mode   = r_mode;
        n_phase  = r_phase;
        n_elem   = r_elem;
        n_marker = r_marker;
        n_spat   = r_spat;
        n_schar  = r_schar;
        n_timer  = r_timer;
        pop      = 1'b0;
        key      = 1'b0;
        dv       = 1'b0;
        dc       = '0;
        ev       = 1'b0;
        ec       = '0;

        // choose the next phase when the key line is idle
        if (n_phase == mkey_pkg::PH_IDLE) begin
            unique case (n_mode)
                mkey_pkg::M_DIT: begin
                    n_marker = n_marker << 1;
                    n_phase  = mkey_pkg::PH_MARK;
                    n_timer  = dl1;
                end
                mkey_pkg::M_DAH: begin
                    n_elem   = n_elem | n_marker;
                    n_marker = n_marker << 1;
                    n_phase  = mkey_pkg::PH_MARK;
                    n_timer  = dl3;
                end
                mkey_pkg::M_ECHAR: begin
                    n_phase = mkey_pkg::PH_GAP;
                    n_timer = dl2;
                end
                mkey_pkg::M_EWORD: begin
                    n_phase = mkey_pkg::PH_GAP;
                    n_timer = dl4;
                end
                mkey_pkg::M_ASCII: begin
                    if (n_spat > 8'd1) begin
                        n_phase = mkey_pkg::PH_MARK;
                        n_timer = n_spat[0] ? dl3 : dl1;
                    end else if (n_spat == 8'd1) begin
                        n_spat  = '0;
                        n_phase = mkey_pkg::PH_GAP;
                        n_timer = dl2;
                    end else if (!cnt_nz) begin
                        n_mode = mkey_pkg::M_START;
                    end else begin
                        pop     = accept;
                        n_schar = head_data;
                        n_spat  = mkey_pkg::pattern_of_char(head_data);
                        if (n_spat > 8'd1) begin
                            n_phase = mkey_pkg::PH_MARK;
                            n_timer = n_spat[0] ? dl3 : dl1;
                        end else begin
                            n_spat  = '0;
                            n_phase = mkey_pkg::PH_GAP;
                            n_timer = dl7;
                        end
                    end
                end
                default: begin
                    n_elem   = '0;
                    n_marker = 8'd1;
                    if (cnt_nz) begin
                        n_mode = mkey_pkg::M_ASCII;
                    end else if (dit) begin
                        n_mode = mkey_pkg::M_DIT;
                    end else if (dah) begin
                        n_mode = mkey_pkg::M_DAH;
                    end else begin
                        n_mode = mkey_pkg::M_START;
                    end
                end
            endcase
        end

        // run the timed phase and close it on its last tick
        if (n_phase != mkey_pkg::PH_IDLE) begin
            key = (n_phase == mkey_pkg::PH_MARK);
            if (n_timer > TW'(1)) begin
                n_timer = n_timer - 1'b1;
            end else if (n_phase == mkey_pkg::PH_MARK) begin
                n_phase = mkey_pkg::PH_SPACE;
                n_timer = dl1;
            end else begin
                n_phase = mkey_pkg::PH_IDLE;
                n_timer = '0;
                unique case (n_mode)
                    mkey_pkg::M_DIT: begin
                        if (n_marker == mkey_pkg::MARKER_LAST) begin
                            n_mode = mkey_pkg::M_ECHAR;
                        end else if (dah) begin
                            n_mode = mkey_pkg::M_DAH;
                        end else if (!dit) begin
                            n_mode = mkey_pkg::M_ECHAR;
                        end
                    end
                    mkey_pkg::M_DAH: begin
                        if (n_marker == mkey_pkg::MARKER_LAST) begin
                            n_mode = mkey_pkg::M_ECHAR;
                        end else if (dit) begin
                            n_mode = mkey_pkg::M_DIT;
                        end else if (!dah) begin
                            n_mode = mkey_pkg::M_ECHAR;
                        end
                    end
                    mkey_pkg::M_ECHAR: begin
                        dv       = 1'b1;
                        dc       = mkey_pkg::char_of_pattern(n_elem | n_marker);
                        n_elem   = '0;
                        n_marker = 8'd1;
                        if (dit) begin
                            n_mode = mkey_pkg::M_DIT;
                        end else if (dah) begin
                            n_mode = mkey_pkg::M_DAH;
                        end else begin
                            n_mode = mkey_pkg::M_EWORD;
                        end
                    end
                    mkey_pkg::M_ASCII: begin
                        if (n_spat > 8'd1) begin
                            n_spat = n_spat >> 1;
                            if (n_spat <= 8'd1) begin
                                n_spat  = '0;
                                n_phase = mkey_pkg::PH_GAP;
                                n_timer = dl2;
                            end
                        end else begin
                            ev     = 1'b1;
                            ec     = n_schar;
                            n_spat = '0;
                            if (!cnt_nz_after) begin
                                n_mode = mkey_pkg::M_START;
                            end
                        end
                    end
                    default: begin
                        n_mode = mkey_pkg::M_START;
                    end
                endcase
            end
        end

        n_out_data = {full, ec, ev, dc, dv, key};
    end

    // state and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dit_len   <= mkey_pkg::DIT_RESET;
            r_mode      <= mkey_pkg::M_START;
            r_phase     <= mkey_pkg::PH_IDLE;
            r_elem      <= '0;
            r_marker    <= 8'd1;
            r_spat      <= '0;
            r_schar     <= '0;
            r_timer     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_dit_len <= i_cfg_wr_data;
            end
            if (accept) begin
                r_mode      <= n_mode;
                r_phase     <= n_phase;
                r_elem      <= n_elem;
                r_marker    <= n_marker;
                r_spat      <= n_spat;
                r_schar     <= n_schar;
                r_timer     <= n_timer;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'b0000, r_out_data};

endmodule
